@@ hw/rtl/gagg_pkg.sv @@
`default_nettype none

package gagg_pkg;

    // Defaults and fixed field widths.
    localparam int MAX_GROUPS_DEF = 16;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 64;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 72;
    localparam int DIV_STEPS      = 80;
    localparam int DIV_CNT_W      = 7;

    // Register indexes, taken from paddr[4:3].
    localparam logic [1:0] REG_AGG_MODE    = 2'd0;
    localparam logic [1:0] REG_GROUP_COUNT = 2'd1;
    localparam logic [1:0] REG_EMPTY_VALUE = 2'd2;

    // Aggregation modes.
    localparam logic [1:0] MODE_SUM  = 2'd0;
    localparam logic [1:0] MODE_MEAN = 2'd1;
    localparam logic [1:0] MODE_MIN  = 2'd2;
    localparam logic [1:0] MODE_MAX  = 2'd3;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    // Divider control and status.
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic done;
        logic sat;
    } div_stat_t;

    // Value an untouched store entry holds in a given mode.
    function automatic logic [63:0] neutral_value(input logic [1:0] mode);
        logic [63:0] v;
        case (mode)
            MODE_MIN: v = S64_MAX;
            MODE_MAX: v = S64_MIN;
            default:  v = 64'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gagg_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle. It divides the magnitude
// shifted left by 16 bits and flags a quotient that does not fit 63 bits.
module gagg_div
    import gagg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire div_ctl_t    ctl,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output div_stat_t        stat,
    output logic      [63:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]          dvd_reg, dvd_next;
    logic [31:0]          dvs_reg, dvs_next;
    logic [31:0]          rem_reg, rem_next;
    logic [63:0]          quo_reg, quo_next;
    logic                 ovf_reg, ovf_next;

    logic [32:0] shifted;
    logic        ge;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[63]};
        ge        = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = 32'd0;
            quo_next  = 64'd0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            // After the 64 magnitude bits, zeros shift in for the 16 fraction bits.
            dvd_next = {dvd_reg[62:0], 1'b0};
            rem_next = ge ? 32'(shifted - {1'b0, dvs_reg}) : shifted[31:0];
            quo_next = {quo_reg[62:0], ge};
            ovf_next = ovf_reg | quo_reg[63];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign stat.done = done_reg;
    assign stat.sat  = ovf_reg | quo_reg[63];
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

@@ hw/rtl/grouped_aggregation.sv @@
`default_nettype none

// A missing or bad sample is handled in the idle state; an accumulated sample reads its
// group's entry, then writes it back. Readout reads, checks and emits each group, dividing first
// for a nonempty group in mean mode. A new sample waits for the store's read-modify-write.
// Mean readout is paced by the bit-serial divider, 80 steps per nonempty group.
// Reset: registers go to sum mode, 16 groups, empty value 0; the valid bits of the store
// clear at once, so every entry reads as its neutral value and no clearing pass is run.
module grouped_aggregation
    import gagg_pkg::*;
#(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // Configuration port.
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready,

    // Sample stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [31:0] sample_value, [39:32] group_id
    input  wire logic [0:0]           s_tuser,  // [0] group_missing
    input  wire logic                 s_tlast,  // last_sample

    // Result stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,  // [4:0] result_group, [68:5] result_value
    output logic      [1:0]           m_tuser,  // [0] group_empty, [1] bad_group
    output logic                      m_tlast   // end_of_run
);

    localparam int IDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam logic [7:0] MAX_GROUPS8 = 8'(MAX_GROUPS);

    // One-hot sequencer. Accumulation reads the entry, then writes it back.
    // Readout walks the groups: read, check, and for the mean divide, then emit.
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ACC    = 6'b000010,
        ST_RO_RD  = 6'b000100,
        ST_RO_CHK = 6'b001000,
        ST_RO_DIV = 6'b010000,
        ST_RO_PUT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [1:0]  mode_reg;
    logic [4:0]  gc_reg;
    logic [63:0] empty_value_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:3];

    always_comb
    begin
        case (cfg_idx)
            REG_AGG_MODE:    prdata = {62'd0, mode_reg};
            REG_GROUP_COUNT: prdata = {59'd0, gc_reg};
            REG_EMPTY_VALUE: prdata = empty_value_reg;
            default:         prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_SUM;
            gc_reg          <= 5'd16;
            empty_value_reg <= 64'd0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_AGG_MODE:    mode_reg        <= pwdata[1:0];
                REG_GROUP_COUNT: gc_reg          <= pwdata[4:0];
                REG_EMPTY_VALUE: empty_value_reg <= pwdata;
                default:         ;
            endcase
        end
    end

    // Groups in use: a count of zero acts as one, and the count is capped at the store size.
    logic [7:0] used_groups;

    always_comb
    begin
        if (gc_reg == 5'd0)
            used_groups = 8'd1;
        else if ({3'd0, gc_reg} > MAX_GROUPS8)
            used_groups = MAX_GROUPS8;
        else
            used_groups = {3'd0, gc_reg};
    end

    // Input decode.
    logic [31:0]      in_sample;
    logic [7:0]       in_gid;
    logic             in_missing;
    logic             in_bad;
    logic [IDX_W-1:0] in_idx;
    logic             in_accept;

    assign in_sample  = s_tdata[31:0];
    assign in_gid     = s_tdata[39:32];
    assign in_missing = s_tuser[0];
    assign in_bad     = (in_gid == 8'd0) || (in_gid > used_groups);
    assign in_idx     = IDX_W'(in_gid - 8'd1);
    assign in_accept  = s_tvalid && s_tready;

    // Group store: one memory word holds the running value above the count.
    // A valid bit per entry stands in for the neutral reset value.
    logic [95:0]           mem [MAX_GROUPS];
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [95:0]           mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic [95:0]           rd_data_reg;
    logic [MAX_GROUPS-1:0] valid_reg, valid_next;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    logic [63:0] rd_acc;
    logic [31:0] rd_tal;

    assign rd_acc = rd_data_reg[95:32];
    assign rd_tal = rd_data_reg[31:0];

    // Sample and readout bookkeeping.
    logic [31:0]      sample_reg, sample_next;
    logic             last_reg, last_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] grp_reg, grp_next;

    // Accumulate: saturating add for sum and mean, compare for minimum and maximum.
    logic [63:0] cur_acc;
    logic [31:0] cur_tal;
    logic [63:0] sample_ext;
    logic [64:0] sum65;
    logic [63:0] sum_sat;
    logic [63:0] new_acc;
    logic [31:0] new_tal;

    always_comb
    begin
        cur_acc    = valid_reg[idx_reg] ? rd_acc : neutral_value(mode_reg);
        cur_tal    = valid_reg[idx_reg] ? rd_tal : 32'd0;
        sample_ext = {{32{sample_reg[31]}}, sample_reg};
        sum65      = {cur_acc[63], cur_acc} + {sample_ext[63], sample_ext};
        if (sum65[64] != sum65[63])
            sum_sat = sum65[64] ? S64_MIN : S64_MAX;
        else
            sum_sat = sum65[63:0];
        case (mode_reg)
            MODE_MIN: new_acc = ($signed(sample_ext) < $signed(cur_acc)) ? sample_ext : cur_acc;
            MODE_MAX: new_acc = ($signed(sample_ext) > $signed(cur_acc)) ? sample_ext : cur_acc;
            default:  new_acc = sum_sat;
        endcase
        new_tal = (cur_tal == 32'hFFFF_FFFF) ? cur_tal : cur_tal + 32'd1;
    end

    // Mean: the shared divider works on the magnitude, the sign is put back after.
    div_ctl_t    div_ctl;
    div_stat_t   div_stat;
    logic [63:0] div_mag;
    logic [63:0] div_quo;
    logic        acc_neg;
    logic [63:0] mean_value;

    assign acc_neg = rd_acc[63];
    assign div_mag = acc_neg ? (64'd0 - rd_acc) : rd_acc;

    gagg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_mag),
        .divisor  (rd_tal),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_comb
    begin
        if (div_stat.sat)
            mean_value = acc_neg ? S64_MIN : S64_MAX;
        else
            mean_value = acc_neg ? (64'd0 - div_quo) : div_quo;
    end

    // Output register.
    logic        out_valid_reg;
    logic [4:0]  out_group_reg;
    logic [63:0] out_value_reg;
    logic        out_empty_reg;
    logic        out_bad_reg;
    logic        out_eor_reg;
    logic        out_free;
    logic        out_load;
    logic [4:0]  load_group;
    logic [63:0] load_value;
    logic        load_empty;
    logic        load_bad;
    logic        load_eor;

    assign out_free = !out_valid_reg || m_tready;

    // Readout helpers.
    logic       grp_last;
    logic       grp_empty;
    logic [4:0] grp_number;

    assign grp_last   = (8'(grp_reg) + 8'd1) == used_groups;
    assign grp_empty  = !valid_reg[grp_reg] || (rd_tal == 32'd0);
    assign grp_number = 5'(8'(grp_reg) + 8'd1);

    assign s_tready = (state_reg == ST_IDLE) && out_free;

    always_comb
    begin
        state_next    = state_reg;
        sample_next   = sample_reg;
        last_next     = last_reg;
        idx_next      = idx_reg;
        grp_next      = grp_reg;
        valid_next    = valid_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = {new_acc, new_tal};
        mem_re        = 1'b0;
        mem_raddr     = grp_reg;
        div_ctl.start = 1'b0;
        out_load      = 1'b0;
        load_group    = grp_number;
        load_value    = rd_acc;
        load_empty    = 1'b0;
        load_bad      = 1'b0;
        load_eor      = grp_last;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next = in_sample;
                    last_next   = s_tlast;
                    idx_next    = in_idx;
                    grp_next    = '0;
                    if (!in_missing && in_bad)
                    begin
                        // Dropped sample: one error beat, readout may still follow.
                        out_load   = 1'b1;
                        load_group = 5'd0;
                        load_value = 64'd0;
                        load_bad   = 1'b1;
                        load_eor   = 1'b1;
                        state_next = s_tlast ? ST_RO_RD : ST_IDLE;
                    end
                    else if (!in_missing)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = in_idx;
                        state_next = ST_ACC;
                    end
                    else
                    begin
                        state_next = s_tlast ? ST_RO_RD : ST_IDLE;
                    end
                end
            end

            ST_ACC:
            begin
                mem_we              = 1'b1;
                valid_next[idx_reg] = 1'b1;
                grp_next            = '0;
                state_next          = last_reg ? ST_RO_RD : ST_IDLE;
            end

            ST_RO_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_RO_CHK;
            end

            ST_RO_CHK:
            begin
                if (!grp_empty && (mode_reg == MODE_MEAN))
                begin
                    div_ctl.start = 1'b1;
                    state_next    = ST_RO_DIV;
                end
                else if (out_free)
                begin
                    out_load = 1'b1;
                    if (grp_empty)
                    begin
                        load_value = empty_value_reg;
                        load_empty = 1'b1;
                    end
                    if (grp_last)
                    begin
                        valid_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        grp_next   = grp_reg + IDX_W'(1);
                        state_next = ST_RO_RD;
                    end
                end
            end

            ST_RO_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_RO_PUT;
            end

            ST_RO_PUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    load_value = mean_value;
                    if (grp_last)
                    begin
                        valid_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        grp_next   = grp_reg + IDX_W'(1);
                        state_next = ST_RO_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A mode change returns the whole store to the new mode's neutral values.
        if (cfg_wr && (cfg_idx == REG_AGG_MODE))
            valid_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            grp_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
            grp_reg   <= grp_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        idx_reg    <= idx_next;
        if (out_load)
        begin
            out_group_reg <= load_group;
            out_value_reg <= load_value;
            out_empty_reg <= load_empty;
            out_bad_reg   <= load_bad;
            out_eor_reg   <= load_eor;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_value_reg, out_group_reg};
    assign m_tuser  = {out_bad_reg, out_empty_reg};
    assign m_tlast  = out_eor_reg;

endmodule

`default_nettype wire
